// ===== rtl/core/rbdc_pkg.sv =====
// Package for the RTC BCD register decode and check block.
// Beat types, field masks, ranges and BCD / calendar helper functions.
// No dependencies.
package rbdc_pkg;

   typedef struct packed {
      logic [7:0] seconds_reg;
      logic [7:0] minutes_reg;
      logic [7:0] hours_reg;
      logic [7:0] date_reg;
      logic [7:0] weekday_reg;
      logic [7:0] month_reg;
      logic [7:0] year_reg;
   } rbdc_req_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  second_out;
      logic [5:0]  minute_out;
      logic [4:0]  hour_out;
      logic [4:0]  day_out;
      logic [2:0]  weekday_out;
      logic [3:0]  month_out;
      logic [11:0] year_out;
   } rbdc_rsp_type;

   // Clock-halt flag in the seconds register.
   localparam int unsigned CH_BIT = 7;

   // Per-field masks of the raw register bytes.
   localparam logic [7:0] SEC_MASK  = 8'h7F;
   localparam logic [7:0] MIN_MASK  = 8'h7F;
   localparam logic [7:0] HOUR_MASK = 8'h3F;
   localparam logic [7:0] DATE_MASK = 8'h3F;
   localparam logic [7:0] WDAY_MASK = 8'h07;
   localparam logic [7:0] MON_MASK  = 8'h1F;
   localparam logic [7:0] YEAR_MASK = 8'hFF;

   // Field limits (binary).
   localparam logic [6:0] SEC_MAX  = 7'd59;
   localparam logic [6:0] MIN_MAX  = 7'd59;
   localparam logic [6:0] HOUR_MAX = 7'd23;
   localparam logic [6:0] DAY_MIN  = 7'd1;
   localparam logic [6:0] DAY_MAX  = 7'd31;
   localparam logic [6:0] WDAY_MAX = 7'd6;
   localparam logic [6:0] MON_MIN  = 7'd1;
   localparam logic [6:0] MON_MAX  = 7'd12;
   localparam logic [6:0] YOFF_MAX = 7'd99;

   localparam logic [11:0] YEAR_BASE = 12'd2000;
   localparam logic [11:0] YEAR_LAST = 12'd2099;

   // Both nibbles are decimal digits.
   function automatic logic bcd_ok(input logic [7:0] v);
      return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
   endfunction

   // tens*10 + units, as shifts and adds; meaningful only when bcd_ok.
   function automatic logic [6:0] bcd_bin(input logic [7:0] v);
      return {v[7:4], 3'b000} + {2'b00, v[7:4], 1'b0} + {3'b000, v[3:0]};
   endfunction

   // Month length; February follows the leap flag.
   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] d;
      unique case (mon)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/rbdc_decode.sv =====
// Combinational decode of one register snapshot into binary calendar fields.
// Depends on rbdc_pkg (types, masks, BCD and month-length helpers).
module rbdc_decode
   import rbdc_pkg::*;
(
   input  rbdc_req_type snap,
   output rbdc_rsp_type result
);

   logic [7:0]  sec_m, min_m, hour_m, date_m, wday_m, mon_m, year_m;
   logic [6:0]  sec_b, min_b, hour_b, day_b, wday_b, mon_b, yoff_b;
   logic        digits_ok, range_ok, leap, day_fits, good;
   logic [11:0] year_full;

   assign sec_m  = snap.seconds_reg & SEC_MASK;
   assign min_m  = snap.minutes_reg & MIN_MASK;
   assign hour_m = snap.hours_reg   & HOUR_MASK;
   assign date_m = snap.date_reg    & DATE_MASK;
   assign wday_m = snap.weekday_reg & WDAY_MASK;
   assign mon_m  = snap.month_reg   & MON_MASK;
   assign year_m = snap.year_reg    & YEAR_MASK;

   assign sec_b  = bcd_bin(sec_m);
   assign min_b  = bcd_bin(min_m);
   assign hour_b = bcd_bin(hour_m);
   assign day_b  = bcd_bin(date_m);
   assign wday_b = bcd_bin(wday_m);
   assign mon_b  = bcd_bin(mon_m);
   assign yoff_b = bcd_bin(year_m);

   assign digits_ok = bcd_ok(sec_m) && bcd_ok(min_m) && bcd_ok(hour_m) && bcd_ok(date_m)
                   && bcd_ok(wday_m) && bcd_ok(mon_m) && bcd_ok(year_m);

   assign range_ok = (sec_b <= SEC_MAX) && (min_b <= MIN_MAX) && (hour_b <= HOUR_MAX)
                  && (day_b >= DAY_MIN) && (day_b <= DAY_MAX) && (wday_b <= WDAY_MAX)
                  && (mon_b >= MON_MIN) && (mon_b <= MON_MAX) && (yoff_b <= YOFF_MAX);

   // 2000..2099: divisible by 4 is leap (2000 is a 400-year).
   assign leap      = (yoff_b[1:0] == 2'b00);
   assign day_fits  = (day_b[4:0] <= month_days(mon_b[3:0], leap));
   assign year_full = YEAR_BASE + {5'b00000, yoff_b};

   assign good = !snap.seconds_reg[CH_BIT] && digits_ok && range_ok && day_fits;

   always_comb begin
      result = '0;
      if (good) begin
         result.ok          = 1'b1;
         result.second_out  = sec_b[5:0];
         result.minute_out  = min_b[5:0];
         result.hour_out    = hour_b[4:0];
         result.day_out     = day_b[4:0];
         result.weekday_out = wday_b[2:0];
         result.month_out   = mon_b[3:0];
         result.year_out    = year_full;
      end
   end

endmodule

// ===== rtl/core/rtc_bcd_register_decode_check_unit.sv =====
// Top level of the RTC BCD register decode and check block.
// Depends on rbdc_pkg and rbdc_decode.
//
// Usage:
//   req channel: one beat is a snapshot of the seven raw RTC time registers
//   (seconds, minutes, hours, date, weekday, month, year).
//   rsp channel: one beat per request, in order: ok plus the binary fields
//   (seconds, minutes, hours, day, weekday, month, full year 2000..2099).
//   A snapshot with clock halt set, a non-decimal digit, a field out of range
//   or a day past the end of its month gives ok = 0 with every field zero.
//   Hours are taken as 24-hour; the 12/24 mode bit is ignored.
// Timing:
//   Input register, decode logic, result register. An accepted request is
//   decoded from the input register and loaded into the result register,
//   which raises rsp_valid. Throughput is one beat per cycle while rsp_ready
//   is high; the decode is a single pass of narrow adds and compares between the registers.
// Stall:
//   When rsp_ready is low the result register holds its beat, the input
//   register still accepts one more beat, and req_ready drops only when both
//   stages are full. Both stages advance together as soon as rsp_ready rises.
// Reset:
//   Synchronous, active high; clears both stage valid flags. Data registers are not reset.
module rtc_bcd_register_decode_check_unit
   import rbdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  rbdc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rbdc_rsp_type rsp_data
);

   // Stage 1: captured snapshot.
   logic         s1_valid_ff, s1_valid_in;
   rbdc_req_type s1_data_ff;
   // Stage 2: decoded result waiting for the receiver.
   logic         s2_valid_ff, s2_valid_in;
   rbdc_rsp_type s2_data_ff;

   rbdc_rsp_type decoded;
   logic         s2_load, s1_load;

   rbdc_decode u_decode (
      .snap   (s1_data_ff),
      .result (decoded)
   );

   // Result stage can take a new beat when empty or being drained.
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign s1_load   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
      if (s2_load) begin
         s2_data_ff <= decoded;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

   // Rejected results carry all-zero fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data == '0))
      else $error("rejected result with nonzero fields");

   // Accepted results are in the calendar window.
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ok) |-> (rsp_data.year_out >= YEAR_BASE)
         && (rsp_data.year_out <= YEAR_LAST) && (rsp_data.month_out != 4'd0)
         && (rsp_data.month_out <= MON_MAX[3:0]) && (rsp_data.day_out != 5'd0))
      else $error("ok result outside calendar range");

   // A captured snapshot that cannot move on stays put.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stage 1 beat lost while stalled");

   // Every accepted request occupies stage 1 next cycle.
   a_req_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request not captured");

   // A stage-1 beat that moves on appears in the result stage.
   a_s2_fill: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid)
      else $error("decoded beat not presented");

endmodule
